### sv/msdw_pkg.sv
// msdw_pkg: shared widths, register indexes, reset values and control types
// for the mid/side delay widener. No dependencies; imported by all modules.

package msdw_pkg;

  // sample and delay line geometry
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF      = 2'd2;

  localparam logic [CFG_W-1:0] SIDE_GAIN_RST = 16'd258;
  localparam logic [CFG_W-1:0] DELAY_RST     = 16'd6095;
  localparam logic [CFG_W-1:0] COEF_RST      = 16'd2768;

  // datapath widths
  localparam int FRAC_W = 16;                  // fraction bits of the low-pass state
  localparam int LP_W   = SAMPLE_BITS + FRAC_W; // low-pass state
  localparam int DIFF_W = LP_W + 1;            // sample minus low-pass state
  localparam int MB_W   = CFG_W;               // multiplier operand, one bit per cycle
  localparam int MH_W   = DIFF_W + 1;          // high half of the shift-add accumulator
  localparam int RND_SH = 15;                  // gain is Q1.15
  localparam int SIDE_W = MH_W + 1 - RND_SH;   // rounded side signal
  localparam int SUM_W  = SIDE_W + 1;          // mid +/- side before saturation

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic start;
    logic b_signed;
  } msdw_mul_ctl_t;

endpackage

### sv/mid_side_delay_widener.sv
// mid_side_delay_widener: haas delay mid/side widener, top level.
// A new sample is accepted only in the idle state, so the next input waits until the
// previous result has been loaded; each sample takes two passes through the
// shared shift-add multiplier, and results wait in an output register.
// Reset (rst_n, synchronous): pointer, low-pass state and registers to default;
// delay line needs no clearing pass, unwritten entries read as zero.

module mid_side_delay_widener (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [msdw_pkg::SAMPLE_BITS-1:0] in_mid_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [msdw_pkg::SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [msdw_pkg::SAMPLE_BITS-1:0] out_right_sample,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [msdw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [msdw_pkg::CFG_W-1:0]              cfg_data
);
  import msdw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_LPUPD = 3'd3;
  localparam logic [2:0] ST_HCALC = 3'd4;
  localparam logic [2:0] ST_MUL2  = 3'd5;
  localparam logic [2:0] ST_ROUND = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CFG_W-1:0]        gain_r, delay_r, coef_r;
  logic signed [LP_W-1:0]  lp_r, lp_nxt;
  sample_t                 mid_r;
  sample_t                 s_r;
  logic signed [SIDE_W-1:0] side_r, side_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sample_t                 left_r, right_r;

  logic                    in_xfer;
  logic                    out_load;
  sample_t                 rd_sample;
  sample_t                 s_sel;
  logic signed [DIFF_W-1:0] s_ext, lp_ext, diff;
  logic signed [MH_W-1:0]  prod_hi;
  logic                    mul_done;
  msdw_mul_ctl_t           mul_ctl;
  logic [MB_W-1:0]         mul_b;
  logic signed [MH_W:0]    lp_sum;
  logic signed [MH_W:0]    rnd_sum;
  logic signed [SUM_W-1:0] mid_ext, side_ext, left_sum, right_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

  // saturate to the signed sample range
  function automatic sample_t sat(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-SAMPLE_BITS:0] top;
    top = x[SUM_W-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      sat = x[SAMPLE_BITS-1:0];
    end else if (x[SUM_W-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= SIDE_GAIN_RST;
      delay_r <= DELAY_RST;
      coef_r  <= COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIDE_GAIN: gain_r  <= cfg_data;
        REG_DELAY:     delay_r <= cfg_data;
        REG_COEF:      coef_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  msdw_delay_line u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_xfer),
    .wr_data   (in_mid_sample),
    .delay     (delay_r),
    .rd_sample (rd_sample)
  );

  // delayed sample in Q.16 minus low-pass state, shared by both passes
  assign s_sel  = (state_r == ST_READ) ? rd_sample : s_r;
  assign s_ext  = {s_sel[SAMPLE_BITS-1], s_sel, {FRAC_W{1'b0}}};
  assign lp_ext = {lp_r[LP_W-1], lp_r};
  assign diff   = s_ext - lp_ext;

  // multiplier: coefficient first, then gain
  assign mul_ctl.start    = (state_r == ST_READ) || (state_r == ST_HCALC);
  assign mul_ctl.b_signed = (state_r == ST_HCALC);
  assign mul_b            = (state_r == ST_HCALC) ? gain_r : coef_r;

  msdw_serial_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .a       (diff),
    .b       (mul_b),
    .done    (mul_done),
    .prod_hi (prod_hi)
  );

  // low-pass step and rounded side signal
  assign lp_sum  = {{3{lp_r[LP_W-1]}}, lp_r} + {prod_hi[MH_W-1], prod_hi};
  assign rnd_sum = {prod_hi[MH_W-1], prod_hi}
                 + {{(MH_W+1-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};

  // mid plus and minus side
  assign mid_ext   = {{(SUM_W-SAMPLE_BITS){mid_r[SAMPLE_BITS-1]}}, mid_r};
  assign side_ext  = {side_r[SIDE_W-1], side_r};
  assign left_sum  = mid_ext + side_ext;
  assign right_sum = mid_ext - side_ext;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    lp_nxt        = lp_r;
    side_nxt      = side_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (mul_done) begin
          state_nxt = ST_LPUPD;
        end
      end
      ST_LPUPD: begin
        lp_nxt    = lp_sum[LP_W-1:0];
        state_nxt = ST_HCALC;
      end
      ST_HCALC: state_nxt = ST_MUL2;
      ST_MUL2: begin
        if (mul_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        side_nxt  = rnd_sum[MH_W:RND_SH];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lp_r        <= lp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    if (in_xfer) begin
      mid_r <= in_mid_sample;
    end
    if (state_r == ST_READ) begin
      s_r <= rd_sample;
    end
    if (out_load) begin
      left_r  <= sat(left_sum);
      right_r <= sat(right_sum);
    end
  end

endmodule

### sv/msdw_delay_line.sv
// msdw_delay_line: circular sample memory with write pointer and fill tracking.
// Depends on msdw_pkg. Unwritten entries read as zero without a clearing pass.

module msdw_delay_line (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic signed [msdw_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic [msdw_pkg::CFG_W-1:0]     delay,
  output logic signed [msdw_pkg::SAMPLE_BITS-1:0] rd_sample
);
  import msdw_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic [ADDR_W-1:0]      wp_r, wp_nxt;
  logic                   wrapped_r, wrapped_nxt;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [SAMPLE_BITS-1:0] new_r;
  logic                   bypass_r;
  logic                   valid_r;

  logic [31:0]            delay_ext;
  logic [ADDR_W-1:0]      delay_mod;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_written;

  // read address wraps modulo the depth
  assign delay_ext  = {{(32-CFG_W){1'b0}}, delay};
  assign delay_mod  = delay_ext[ADDR_W-1:0];
  assign rd_addr    = wp_r - delay_mod;
  assign rd_written = wrapped_r || (rd_addr < wp_r);

  // pointer advance and wrap flag
  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (wr_en) begin
      wp_nxt = wp_r + 1'b1;
      if (wp_r == {ADDR_W{1'b1}}) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
      q_r       <= mem[rd_addr];
    end
  end

  // bypass and fill status captured with the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      new_r    <= wr_data;
      bypass_r <= (delay_mod == '0);
      valid_r  <= rd_written;
    end
  end

  // zero delay returns the new sample, unwritten entries read zero
  always_comb begin
    if (bypass_r) begin
      rd_sample = new_r;
    end else if (valid_r) begin
      rd_sample = q_r;
    end else begin
      rd_sample = '0;
    end
  end

endmodule

### sv/msdw_serial_mult.sv
// msdw_serial_mult: shift-add multiplier, one multiplier bit per cycle.
// Depends on msdw_pkg. Returns floor(a * b / 2^MB_W); b signed or unsigned.

module msdw_serial_mult (
  input  logic                            clk,
  input  logic                            rst_n,
  input  msdw_pkg::msdw_mul_ctl_t         ctl,
  input  logic signed [msdw_pkg::DIFF_W-1:0] a,
  input  logic [msdw_pkg::MB_W-1:0]       b,
  output logic                            done,
  output logic signed [msdw_pkg::MH_W-1:0] prod_hi
);
  import msdw_pkg::*;

  localparam int CNT_W = $clog2(MB_W);

  logic signed [DIFF_W-1:0] a_r;
  logic                     b_signed_r;
  logic [MB_W-1:0]          l_r, l_nxt;
  logic signed [MH_W-1:0]   h_r, h_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     run_r, run_nxt;

  logic                     last_step;
  logic signed [MH_W-1:0]   a_ext;
  logic signed [MH_W-1:0]   addend;
  logic signed [MH_W-1:0]   sum;

  assign last_step = (cnt_r == CNT_W'(MB_W - 1));
  assign done      = run_r && last_step;
  assign prod_hi   = h_r;

  // partial product: add, subtract on a signed top bit, or skip
  assign a_ext = {a_r[DIFF_W-1], a_r};
  always_comb begin
    if (!l_r[0]) begin
      addend = '0;
    end else if (b_signed_r && last_step) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
  end
  assign sum = h_r + addend;

  // accumulator shifts right, multiplier bits leave at the bottom
  always_comb begin
    h_nxt   = h_r;
    l_nxt   = l_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctl.start) begin
      h_nxt   = '0;
      l_nxt   = b;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      h_nxt   = {sum[MH_W-1], sum[MH_W-1:1]};
      l_nxt   = {sum[0], l_r[MB_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last_step) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    l_r <= l_nxt;
    if (ctl.start) begin
      a_r        <= a;
      b_signed_r <= ctl.b_signed;
    end
  end

endmodule
